// ----- src/pfi_pkg.sv -----
// Package for the particle force integrator: command codes, payload structs,
// sequencer states and fixed widths. Used by particle_force_integrator and its testbench.
package pfi_pkg;

	localparam int DataW = 32;
	localparam int FricW = 16;
	localparam logic [FricW-1:0] FrictionReset = 16'd655;

	typedef enum logic [2:0] {
		CMD_LOAD    = 3'd0,
		CMD_CLEAR   = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_REPEL   = 3'd3,
		CMD_ATTRACT = 3'd4,
		CMD_UPDATE  = 3'd5
	} cmd_t;

	localparam logic [0:0] REG_FRICTION = 1'b0;
	localparam logic [0:0] REG_HOLD     = 1'b1;

	typedef struct packed {
		logic [2:0]        cmd;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic [30:0]       reach;
		logic signed [31:0] strength;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,     // accumulate d^2, one axis per cycle
		ST_SQRT,   // one root bit per cycle
		ST_QDIV,   // q = dist*65536/reach, one quotient bit per cycle
		ST_AXMUL,  // |d|*|pct|
		ST_AXDIV,  // /dist, one bit per cycle
		ST_AXSTR,  // *|strength|, accumulate
		ST_FRIC,   // friction per axis
		ST_INTEG,  // velocity and position per axis
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) return 32'sh7fffffff;
		else if (v < -35'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

endpackage

// ----- src/particle_force_integrator.sv -----
// Top level of the particle force integrator.
// Depends on pfi_pkg and pfi_divider.
//
// One particle (position, velocity, force sum, Q16.16) is advanced by commands.
// Input channel in_valid/in_stall carries one in_item_t per beat; output channel
// out_valid/out_stall returns one out_item_t (position and velocity) per input beat.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set friction
// (index 0) and hold (index 1); cfg_ready is always high.
// One item is worked at a time. Load, clear, add and the spare codes go straight to
// the result; update applies friction per axis and then, unless hold is set,
// integrates velocity and position per axis. Repel and attract share one multiplier
// and one bit-serial divider: squares, square root, a division for the falloff and,
// per axis (x and y only for attract), a multiply, a division and a multiply; zero
// reach, zero distance or a repel point out of reach finish after the square root.
// The next beat is taken in the cycle after a result is registered. A stalled
// result beat holds in the output register; meanwhile one more input beat is
// taken and worked, and its result waits with the input stalled until the
// earlier beat leaves.
// Reset clears the state to zero, friction to 655 and hold to 0.
module particle_force_integrator #(
	parameter logic [pfi_pkg::FricW-1:0] FRICTION_RESET = pfi_pkg::FrictionReset
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pfi_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output pfi_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import pfi_pkg::*;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [FricW-1:0] fric_q;
	logic hold_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] frc_q [3];
	logic signed [32:0] d_q [3];
	logic [67:0] sumsq_q;
	logic [33:0] root_q;
	logic [33:0] rem_q;
	logic [5:0]  cnt_q;
	logic [1:0]  ax_q;
	logic [31:0] pmag_q;
	logic        pneg_q;
	logic [63:0] prod_q;
	logic        out_valid_q;

	// shared multiplier, 33 x 33 magnitudes
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic [32:0] dmag;
	always_comb begin
		dmag = d_q[ax_q][32] ? -d_q[ax_q] : d_q[ax_q];
	end

	// divider
	logic        div_start;
	logic [63:0] div_n;
	logic [32:0] div_d;
	logic [63:0] div_q;
	logic [6:0]  dcnt_q;
	pfi_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .quotient(div_q)
	);

	// square root step
	logic [35:0] sq_rem;
	logic [35:0] sq_trial;
	assign sq_rem   = {rem_q, sumsq_q[67:66]};
	assign sq_trial = {root_q, 2'b01};

	logic [31:0] smag;
	assign smag = item_q.strength[31] ? 32'(-item_q.strength) : 32'(item_q.strength);
	logic [32:0] span;
	assign span = root_q[32:0];
	logic [1:0] last_ax;
	assign last_ax = (item_q.cmd == CMD_ATTRACT) ? 2'd1 : 2'd2;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ:    begin mul_a = dmag; mul_b = dmag; end
			ST_AXMUL: begin mul_a = dmag; mul_b = {1'b0, pmag_q}; end
			ST_AXSTR: begin mul_a = prod_q[32:0]; mul_b = {1'b0, smag}; end
			ST_FRIC:  begin
				mul_a = vel_q[ax_q][31] ? 33'(-vel_q[ax_q]) : 33'(vel_q[ax_q]);
				mul_b = {17'b0, fric_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (in_data.cmd)
					CMD_REPEL, CMD_ATTRACT: state_d = ST_SQ;
					CMD_UPDATE:             state_d = ST_FRIC;
					default:                state_d = ST_OUT;
				endcase
			end
			ST_SQ: if (ax_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == 6'd0) state_d = ST_QDIV;
			ST_QDIV: begin
				div_n = {30'b0, root_q} << 16;
				div_d = {2'b0, item_q.reach};
				if (item_q.reach == '0 || root_q == '0 ||
				    (item_q.cmd == CMD_REPEL && root_q > {3'b0, item_q.reach}))
					state_d = ST_OUT;
				else if (dcnt_q == 7'd0) div_start = 1'b1;
				else if (dcnt_q == 7'd65) state_d = ST_AXMUL;
			end
			ST_AXMUL: state_d = ST_AXDIV;
			ST_AXDIV: begin
				div_n = prod_q;
				div_d = span;
				if (dcnt_q == 7'd0) div_start = 1'b1;
				else if (dcnt_q == 7'd65) state_d = ST_AXSTR;
			end
			ST_AXSTR: state_d = (ax_q == last_ax) ? ST_OUT : ST_AXMUL;
			ST_FRIC:  if (ax_q == 2'd2) state_d = hold_q ? ST_OUT : ST_INTEG;
			ST_INTEG: if (ax_q == 2'd2) state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fric_q      <= FRICTION_RESET;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
			ax_q        <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				frc_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == REG_FRICTION) fric_q <= cfg_data;
				else hold_q <= cfg_data[0];
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					ax_q    <= '0;
					sumsq_q <= '0;
					case (in_data.cmd)
						CMD_LOAD: begin
							pos_q[0] <= in_data.ax; pos_q[1] <= in_data.ay;
							pos_q[2] <= in_data.az;
							vel_q[0] <= in_data.bx; vel_q[1] <= in_data.by;
							vel_q[2] <= in_data.bz;
						end
						CMD_CLEAR: for (int i = 0; i < 3; i++) frc_q[i] <= '0;
						CMD_ADD: begin
							frc_q[0] <= sat32(35'(frc_q[0]) + 35'(in_data.ax));
							frc_q[1] <= sat32(35'(frc_q[1]) + 35'(in_data.ay));
							frc_q[2] <= sat32(35'(frc_q[2]) + 35'(in_data.az));
						end
						default: ;
					endcase
				end
				ST_SQ: begin
					sumsq_q <= sumsq_q + 68'(mul_p);
					ax_q    <= ax_q + 2'd1;
					cnt_q   <= 6'd33;
					root_q  <= '0;
					rem_q   <= '0;
					dcnt_q  <= '0;
				end
				ST_SQRT: begin
					if (sq_rem >= sq_trial) begin
						rem_q  <= 34'(sq_rem - sq_trial);
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						rem_q  <= sq_rem[33:0];
						root_q <= {root_q[32:0], 1'b0};
					end
					sumsq_q <= sumsq_q << 2;
					if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
				end
				ST_QDIV: begin
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'd65) begin
						dcnt_q <= '0;
						ax_q   <= '0;
						if (div_q > 64'd2147549184) begin
							pmag_q <= 32'h80000000; pneg_q <= 1'b1;
						end else if (div_q > 64'd65536) begin
							pmag_q <= 32'(div_q - 64'd65536); pneg_q <= 1'b1;
						end else begin
							pmag_q <= 32'(64'd65536 - div_q); pneg_q <= 1'b0;
						end
					end
				end
				ST_AXMUL: prod_q <= mul_p[63:0];
				ST_AXDIV: begin
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'd65) begin
						dcnt_q <= '0;
						prod_q <= div_q;
					end
				end
				ST_AXSTR: begin : axstr
					logic [49:0] dm;
					logic signed [51:0] acc;
					dm = 50'(mul_p >> 16);
					if ((d_q[ax_q][32] ^ pneg_q ^ item_q.strength[31]) ^
					    (item_q.cmd == CMD_ATTRACT))
						acc = 52'(frc_q[ax_q]) - 52'(dm);
					else
						acc = 52'(frc_q[ax_q]) + 52'(dm);
					if (acc > 52'sd2147483647) frc_q[ax_q] <= 32'sh7fffffff;
					else if (acc < -52'sd2147483648) frc_q[ax_q] <= 32'sh80000000;
					else frc_q[ax_q] <= acc[31:0];
					ax_q <= ax_q + 2'd1;
				end
				ST_FRIC: begin : fric
					logic signed [33:0] fr;
					fr = vel_q[ax_q][31] ? -34'(mul_p[47:16]) : 34'(mul_p[47:16]);
					frc_q[ax_q] <= sat32(35'(frc_q[ax_q]) - 35'(fr));
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				ST_INTEG: begin : integ
					logic signed [31:0] nv;
					logic signed [31:0] ext;
					nv  = sat32(35'(vel_q[ax_q]) + 35'(frc_q[ax_q]));
					ext = (ax_q == 2'd0) ? item_q.bx : (ax_q == 2'd1) ? item_q.by
					      : item_q.bz;
					vel_q[ax_q] <= nv;
					pos_q[ax_q] <= sat32(35'(pos_q[ax_q]) + 35'(ext) + 35'(nv));
					ax_q <= ax_q + 2'd1;
				end
				ST_OUT: if (!out_valid_q) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
			d_q[0] <= 33'(pos_q[0]) - 33'(in_data.ax);
			d_q[1] <= 33'(pos_q[1]) - 33'(in_data.ay);
			d_q[2] <= 33'(pos_q[2]) - 33'(in_data.az);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !out_valid_q) begin
			out_data.pos_x <= pos_q[0];
			out_data.pos_y <= pos_q[1];
			out_data.pos_z <= pos_q[2];
			out_data.vel_x <= vel_q[0];
			out_data.vel_y <= vel_q[1];
			out_data.vel_z <= vel_q[2];
		end
	end
endmodule

// ----- src/pfi_divider.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
// Stands alone; the caller counts the 64 steps and then reads the quotient.
module pfi_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [32:0] divisor,
	output logic [63:0] quotient
);
	logic [63:0] quot_q;
	logic [33:0] rem_q;
	logic [32:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] shifted;
	logic [34:0] diff;

	assign shifted = {rem_q[32:0], quot_q[63]};
	assign diff    = {1'b0, shifted} - {2'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[34]) begin
				rem_q  <= diff[33:0];
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quot_q;
endmodule

// ----- verif/particle_force_integrator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for particle_force_integrator: a directed table, then random commands.
// Results are predicted cycle-free in the bench itself. Depends on pfi_pkg and the RTL in src.
module particle_force_integrator_tb;
	import pfi_pkg::*;

	// Codes 6 and 7 are not commands. The block must leave its state alone on them.
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic signed [31:0] QMAX = 32'sh7fffffff;
	localparam logic signed [31:0] QMIN = 32'sh80000000;
	localparam logic signed [31:0] ONE  = 32'sh00010000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	particle_force_integrator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Shadow of the particle and of the two registers, advanced once per accepted beat.
	logic signed [31:0] pos_sh [3];
	logic signed [31:0] vel_sh [3];
	logic signed [31:0] force_sh [3];
	logic [15:0]        friction_sh;
	logic               hold_sh;

	out_item_t pending_states[$];
	int        mismatches = 0;
	bit        calm = 1'b0;   // while set, neither side idles

	function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) return QMAX;
		if (v < -68'sd2147483648) return QMIN;
		return v[31:0];
	endfunction

	function automatic logic [127:0] floor_root(input logic [127:0] v);
		logic [127:0] root, rem, trial;
		root = 0;
		rem = 0;
		for (int i = 33; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// Radial field around the point in ax/ay/az. Repulsion works on all three axes
	// inside the reach only; attraction works on x and y everywhere and flips to a
	// push beyond the reach, where the falloff goes negative.
	function automatic void apply_field(input in_item_t it, input bit pull);
		logic signed [33:0] sep [3];
		logic signed [31:0] pt [3];
		logic [127:0] sumsq, span, q, pm, sm, dm, m;
		logic signed [67:0] pct, delta;
		bit neg;
		pt[0] = it.ax;
		pt[1] = it.ay;
		pt[2] = it.az;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			sep[i] = 34'(pos_sh[i]) - 34'(pt[i]);
			m = sep[i][33] ? 128'(-sep[i]) : 128'(sep[i]);
			sumsq = sumsq + m * m;
		end
		if (it.reach == 0) return;
		span = floor_root(sumsq);
		if (span == 0) return;
		if (!pull && span > 128'(it.reach)) return;
		q = (span << 16) / 128'(it.reach);
		if (q > 128'd65536 + 128'd2147483648) pct = -68'sd2147483648;
		else pct = 68'sd65536 - 68'(q);
		if (pct < -68'sd2147483648) pct = -68'sd2147483648;
		pm = pct < 0 ? 128'(-pct) : 128'(pct);
		sm = it.strength[31] ? 128'(-33'(it.strength)) : 128'(it.strength);
		for (int i = 0; i < (pull ? 2 : 3); i++) begin
			m = sep[i][33] ? 128'(-sep[i]) : 128'(sep[i]);
			dm = (((m * pm) / span) * sm) >> 16;
			neg = sep[i][33] ^ (pct < 0) ^ it.strength[31] ^ pull;
			delta = neg ? -68'(dm) : 68'(dm);
			force_sh[i] = clamp32(68'(force_sh[i]) + delta);
		end
	endfunction

	function automatic out_item_t advance_particle(input in_item_t it);
		logic signed [31:0] fa [3];
		logic signed [31:0] fb [3];
		logic [63:0] fm;
		logic signed [67:0] fr;
		fa[0] = it.ax; fa[1] = it.ay; fa[2] = it.az;
		fb[0] = it.bx; fb[1] = it.by; fb[2] = it.bz;
		case (it.cmd)
			CMD_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					pos_sh[i] = fa[i];
					vel_sh[i] = fb[i];
				end
			end
			CMD_CLEAR: for (int i = 0; i < 3; i++) force_sh[i] = 0;
			CMD_ADD:
				for (int i = 0; i < 3; i++) force_sh[i] = clamp32(68'(force_sh[i]) + 68'(fa[i]));
			CMD_REPEL:   apply_field(it, 1'b0);
			CMD_ATTRACT: apply_field(it, 1'b1);
			CMD_UPDATE: begin
				// Friction is scaled on the magnitude, so it truncates toward zero.
				for (int i = 0; i < 3; i++) begin
					fm = ((vel_sh[i][31] ? 64'(-33'(vel_sh[i])) : 64'(vel_sh[i]))
						* 64'(friction_sh)) >> 16;
					fr = vel_sh[i][31] ? -68'(fm) : 68'(fm);
					force_sh[i] = clamp32(68'(force_sh[i]) - fr);
				end
				if (!hold_sh) begin
					for (int i = 0; i < 3; i++) begin
						vel_sh[i] = clamp32(68'(vel_sh[i]) + 68'(force_sh[i]));
						pos_sh[i] = clamp32(68'(pos_sh[i]) + 68'(fb[i]) + 68'(vel_sh[i]));
					end
				end
			end
			default: ;
		endcase
		return '{pos_sh[0], pos_sh[1], pos_sh[2], vel_sh[0], vel_sh[1], vel_sh[2]};
	endfunction

	function automatic in_item_t mk_item(input logic [2:0] c,
		input logic signed [31:0] ax, ay, az, bx, by, bz,
		input logic [30:0] r, input logic signed [31:0] s);
		return '{c, ax, ay, az, bx, by, bz, r, s};
	endfunction

	// Drive one beat. The sender may idle first; valid stays high across back-to-back
	// beats so it is never dropped and raised in the same step.
	task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t got;
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = advance_particle(it);
		pending_states.push_back(typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Registers change only with nothing in flight.
	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRICTION) friction_sh = val;
		else hold_sh = val[0];
	endtask

	// Mostly points near the particle so the field lands inside its reach,
	// sometimes anywhere in the full range.
	function automatic logic signed [31:0] near_coord(input int axis);
		if ($urandom_range(99) < 25) return $urandom;
		return clamp32(68'(pos_sh[axis]) + 68'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff));
	endfunction

	function automatic logic signed [31:0] wide_or_small();
		if ($urandom_range(99) < 30) return $urandom;
		return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		it = '0;
		it.ax = $urandom; it.ay = $urandom; it.az = $urandom;
		it.bx = wide_or_small(); it.by = wide_or_small(); it.bz = wide_or_small();
		it.reach = 31'($urandom);
		it.strength = wide_or_small();
		pick = $urandom_range(99);
		if (pick < 35) it.cmd = CMD_UPDATE;
		else if (pick < 48) it.cmd = CMD_ADD;
		else if (pick < 63) it.cmd = CMD_REPEL;
		else if (pick < 78) it.cmd = CMD_ATTRACT;
		else if (pick < 88) it.cmd = CMD_LOAD;
		else if (pick < 95) it.cmd = CMD_CLEAR;
		else it.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
		if (it.cmd == CMD_REPEL || it.cmd == CMD_ATTRACT) begin
			it.ax = near_coord(0);
			it.ay = near_coord(1);
			it.az = near_coord(2);
			if ($urandom_range(99) < 60) it.reach = 31'($urandom_range(1, 32'h80000));
			else if ($urandom_range(99) < 10) it.reach = '0;
		end else if (it.cmd == CMD_ADD && $urandom_range(99) < 70) begin
			it.ax = wide_or_small(); it.ay = wide_or_small(); it.az = wide_or_small();
		end
		return it;
	endfunction

	// Output side: random stalls, and every beat checked against the oldest state.
	function automatic void check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_states.size() == 0) begin
				$error("result beat with nothing outstanding");
				mismatches++;
			end else begin
				want = pending_states.pop_front();
				check_field("pos_x", want.pos_x, out_data.pos_x);
				check_field("pos_y", want.pos_y, out_data.pos_y);
				check_field("pos_z", want.pos_z, out_data.pos_z);
				check_field("vel_x", want.vel_x, out_data.vel_x);
				check_field("vel_y", want.vel_y, out_data.vel_y);
				check_field("vel_z", want.vel_z, out_data.vel_z);
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 8);
	end

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		out_item_t zero_st, top_st, home_st;
		logic signed [31:0] p10, m3;
		p10 = 32'sh000a0000;
		m3  = 32'shfffd0000;
		zero_st = '0;
		top_st  = '{QMAX, QMIN, 1, QMIN, QMAX, -1};
		home_st = '{p10, 0, m3, 0, 0, 0};

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		friction_sh = 16'd655;
		hold_sh = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pos_sh[i] = 0; vel_sh[i] = 0; force_sh[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Rows whose answer is plain carry it; the rest use the shadow.
		rows.push_back('{mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_st});
		rows.push_back('{mk_item(CMD_LOAD, QMAX, QMIN, 1, QMIN, QMAX, -1, 0, 0), 1, top_st});
		rows.push_back('{mk_item(CMD_SPARE6, QMIN, QMAX, -1, 1, 1, 1, 31'h7fffffff, QMIN),
			1, top_st});
		rows.push_back('{mk_item(CMD_SPARE7, -1, -1, -1, -1, -1, -1, 31'h7fffffff, -1),
			1, top_st});
		rows.push_back('{mk_item(CMD_ADD, QMAX, QMIN, 0, 0, 0, 0, 0, 0), 1, top_st});
		rows.push_back('{mk_item(CMD_ADD, QMAX, QMIN, QMIN, 0, 0, 0, 0, 0), 1, top_st});
		rows.push_back('{mk_item(CMD_UPDATE, 0, 0, 0, QMAX, QMIN, QMAX, 0, 0), 0, zero_st});
		rows.push_back('{mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_st});
		rows.push_back('{mk_item(CMD_LOAD, p10, 0, m3, 0, 0, 0, 0, 0), 1, home_st});
		// Zero reach, zero distance (repel and attract), a repel point out of reach: no change.
		rows.push_back('{mk_item(CMD_REPEL, 0, 0, 0, 0, 0, 0, 0, ONE), 1, home_st});
		rows.push_back('{mk_item(CMD_REPEL, p10, 0, m3, 0, 0, 0, ONE, ONE), 1, home_st});
		rows.push_back('{mk_item(CMD_ATTRACT, p10, 0, m3, 0, 0, 0, ONE, ONE), 1, home_st});
		rows.push_back('{mk_item(CMD_REPEL, -p10, 0, 0, 0, 0, 0, ONE, ONE), 1, home_st});
		rows.push_back('{mk_item(CMD_REPEL, 32'sh00090000, 0, m3, 0, 0, 0, 31'h40000,
			32'sh20000), 0, zero_st});
		rows.push_back('{mk_item(CMD_REPEL, 32'sh00098000, ONE, -ONE, 0, 0, 0, 31'h7fffffff,
			QMIN), 0, zero_st});
		// Attraction beyond its reach turns into a push; the second row lies inside the reach.
		rows.push_back('{mk_item(CMD_ATTRACT, 0, 32'sh50000, 0, 0, 0, 0, ONE, ONE), 0, zero_st});
		rows.push_back('{mk_item(CMD_ATTRACT, 32'sh000b0000, 0, 0, 0, 0, 0, 31'h80000,
			QMAX), 0, zero_st});
		rows.push_back('{mk_item(CMD_UPDATE, 0, 0, 0, ONE, -ONE, 0, 0, 0), 0, zero_st});
		rows.push_back('{mk_item(CMD_LOAD, QMIN, QMIN, QMIN, QMAX, QMIN, 0, 0, 0), 0, zero_st});
		// A huge distance over the smallest reach drives the falloff to its floor.
		rows.push_back('{mk_item(CMD_ATTRACT, QMAX, QMAX, QMAX, 0, 0, 0, 31'd1, QMIN),
			0, zero_st});
		rows.push_back('{mk_item(CMD_REPEL, QMAX, QMAX, QMAX, 0, 0, 0, 31'h7fffffff, QMAX),
			0, zero_st});
		rows.push_back('{mk_item(CMD_UPDATE, 0, 0, 0, QMIN, QMIN, QMIN, 0, 0), 0, zero_st});
		foreach (rows[i]) send_beat(rows[i].it, rows[i].typed, rows[i].want);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(REG_FRICTION, 16'd0);
				1: write_reg(REG_FRICTION, 16'hffff);
				2: write_reg(REG_HOLD, 16'd1);
				3: write_reg(REG_HOLD, 16'd0);
				4: write_reg(REG_FRICTION, 16'($urandom));
				default: write_reg(REG_FRICTION, 16'd655);
			endcase
			calm = (ph == 3);
			for (int n = 0; n < 75; n++) begin
				// Once, the sender holds off until the block has answered everything.
				if (ph == 2 && n == 40) drain();
				send_beat(random_item(), 1'b0, zero_st);
			end
			calm = 1'b0;
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
src/pfi_pkg.sv
src/pfi_divider.sv
src/particle_force_integrator.sv
verif/particle_force_integrator_tb.sv
